FILE: hdl/jsu_pkg.sv
// Package for the JSON string unescape block.
// It holds the shared constants, the types and the character and UTF-8 helper functions.
// It depends on nothing else.
package jsu_pkg;

  localparam int CAP_W = 17;
  localparam logic [CAP_W-1:0] CAP_LIMIT = 17'd65536;
  localparam logic [CAP_W-1:0] CAP_RESET = 17'd4096;

  localparam int CFG_AW = 3;
  localparam logic REG_CAPACITY = 1'b0;

  localparam int MAX_BYTES = 6;
  localparam int NB_W = 3;
  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;

  localparam logic [15:0] SURR_HI_LO = 16'hD800;
  localparam logic [15:0] SURR_HI_HI = 16'hDBFF;
  localparam logic [15:0] SURR_LO_LO = 16'hDC00;
  localparam logic [15:0] SURR_LO_HI = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  typedef enum logic [1:0] {
    PH_TEXT,
    PH_ESC,
    PH_HEX
  } phase_t;

  typedef struct packed {
    logic [8*MAX_BYTES-1:0] bytes;
    logic [NB_W-1:0]        nbytes;
    logic                   last;
    logic                   trunc;
  } pkt_t;

  typedef struct packed {
    logic [2:0]  len;
    logic [31:0] b;
  } utf8_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30;
    end else if (c inside {[8'h61:8'h66]}) begin
      d = c - 8'h57;
    end else if (c inside {[8'h41:8'h46]}) begin
      d = c - 8'h37;
    end
    return d[3:0];
  endfunction

  function automatic logic [7:0] escape_char(input logic [7:0] e);
    logic [7:0] r;
    case (e)
      CH_B:    r = 8'h08;
      CH_F:    r = 8'h0C;
      CH_N:    r = 8'h0A;
      CH_R:    r = 8'h0D;
      CH_T:    r = 8'h09;
      default: r = e;
    endcase
    return r;
  endfunction

  // First byte lands in the low bits; unused bytes are zero.
  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t u;
    u = '0;
    if (cp < 21'h80) begin
      u.len = 3'd1;
      u.b   = {24'h0, cp[7:0]};
    end else if (cp < 21'h800) begin
      u.len = 3'd2;
      u.b   = {16'h0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
    end else if (cp < 21'h10000) begin
      u.len = 3'd3;
      u.b   = {8'h0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
    end else begin
      u.len = 3'd4;
      u.b   = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
    end
    return u;
  endfunction

endpackage

FILE: hdl/jsu_if.sv
// Channel interfaces for the JSON string unescape block.
// jsu_in_if carries raw string bytes, jsu_out_if carries decoded UTF-8 results.
// No dependencies.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_end;

  modport source(output valid, output in_byte, output string_end, input ready);
  modport sink(input valid, input in_byte, input string_end, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       string_done;
  logic       truncated;

  modport source(output valid, output out_byte, output byte_valid, output run_last,
                 output string_done, output truncated, input ready);
  modport sink(input valid, input out_byte, input byte_valid, input run_last,
               input string_done, input truncated, output ready);
endinterface

FILE: hdl/json_string_unescape_utf8.sv
// JSON string unescape to UTF-8. The output side sends a request's result bytes one at a
// time, so a request that expands to more than one byte holds it longer, while requests
// that yield no byte (a backslash, a hex digit) are not queued unless they end the string;
// plain bytes flow at one request per cycle unless the queue fills or dout.ready is low.
// The output byte register sets this rate, and a four-entry packet queue lets input run
// ahead of it. The capacity register sits at byte address 0 of the APB port; write it
// only while the block is idle.
module json_string_unescape_utf8 (
  input  logic                       clk,
  input  logic                       rst,
  jsu_in_if.sink                     din,
  jsu_out_if.source                  dout,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [jsu_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [jsu_pkg::CAP_W-1:0] cap;
  logic               push, pop;
  jsu_pkg::pkt_t      pkt_in, pkt_head;
  jsu_pkg::q_status_t qs;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == jsu_pkg::REG_CAPACITY) ? 32'(cap) : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= jsu_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == jsu_pkg::REG_CAPACITY) begin
      cap <= pwdata[jsu_pkg::CAP_W-1:0];
    end
  end

  jsu_front u_front (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .cap  (cap),
    .qs   (qs),
    .push (push),
    .pkt  (pkt_in)
  );

  jsu_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (pkt_in),
    .pop  (pop),
    .head (pkt_head),
    .qs   (qs)
  );

  jsu_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (pkt_head),
    .qs   (qs),
    .pop  (pop),
    .dout (dout)
  );

endmodule

FILE: hdl/jsu_front.sv
// Front end of the JSON string unescape block: escape decoding, surrogate pairing,
// UTF-8 encoding and the output budget, one input request per cycle while the queue is not full.
// Depends on jsu_pkg and jsu_in_if.
module jsu_front (
  input  logic                     clk,
  input  logic                     rst,
  jsu_in_if.sink                   din,
  input  logic [jsu_pkg::CAP_W-1:0] cap,
  input  jsu_pkg::q_status_t       qs,
  output logic                     push,
  output jsu_pkg::pkt_t            pkt
);

  jsu_pkg::phase_t phase, phase_next;
  logic [15:0] hex_value, hex_value_next;
  logic [1:0]  digit_count, digit_count_next;
  logic        high_pending, high_pending_next;
  logic [9:0]  high_bits, high_bits_next;
  logic [jsu_pkg::CAP_W-1:0] bytes_written, bytes_written_next;
  logic        overflow, overflow_next;

  logic        acc;
  logic [15:0] hv;
  logic        flush_a, flush_c, use_raw, use_cp;
  logic [7:0]  raw;
  logic [20:0] cp;
  jsu_pkg::utf8_t enc_a, enc_b, enc_c;
  logic [2:0]  len_ab;
  logic [3:0]  ntot;
  logic [jsu_pkg::CAP_W-1:0] cap_eff, room;
  logic [2:0]  emit;

  assign din.ready = !qs.full;
  assign acc = din.valid && din.ready;
  assign hv = {hex_value[11:0], jsu_pkg::hex_digit(din.in_byte)};

  always_comb begin
    phase_next = phase;
    hex_value_next = hex_value;
    digit_count_next = digit_count;
    high_pending_next = high_pending;
    high_bits_next = high_bits;
    flush_a = 1'b0;
    use_raw = 1'b0;
    use_cp = 1'b0;
    raw = din.in_byte;
    cp = {5'b0, hv};
    case (phase)
      jsu_pkg::PH_ESC: begin
        if (din.in_byte == jsu_pkg::CH_U) begin
          phase_next = jsu_pkg::PH_HEX;
          digit_count_next = 2'd0;
          hex_value_next = 16'h0;
        end else begin
          flush_a = high_pending;
          high_pending_next = 1'b0;
          use_raw = 1'b1;
          raw = jsu_pkg::escape_char(din.in_byte);
          phase_next = jsu_pkg::PH_TEXT;
        end
      end
      jsu_pkg::PH_HEX: begin
        hex_value_next = hv;
        if (digit_count == 2'd3) begin
          phase_next = jsu_pkg::PH_TEXT;
          digit_count_next = 2'd0;
          if (high_pending && hv >= jsu_pkg::SURR_LO_LO && hv <= jsu_pkg::SURR_LO_HI) begin
            high_pending_next = 1'b0;
            use_cp = 1'b1;
            cp = {1'b0, high_bits, hv[9:0]} + jsu_pkg::SUPP_BASE;
          end else begin
            flush_a = high_pending;
            if (hv >= jsu_pkg::SURR_HI_LO && hv <= jsu_pkg::SURR_HI_HI) begin
              high_pending_next = 1'b1;
              high_bits_next = hv[9:0];
            end else begin
              high_pending_next = 1'b0;
              use_cp = 1'b1;
            end
          end
        end else begin
          digit_count_next = digit_count + 2'd1;
        end
      end
      default: begin
        phase_next = jsu_pkg::PH_TEXT;
        if (din.in_byte == jsu_pkg::CH_BSLASH) begin
          phase_next = jsu_pkg::PH_ESC;
        end else begin
          flush_a = high_pending;
          high_pending_next = 1'b0;
          use_raw = 1'b1;
        end
      end
    endcase
    flush_c = din.string_end && high_pending_next;
  end

  always_comb begin
    enc_a = flush_a ? jsu_pkg::utf8_encode({5'b0, jsu_pkg::SURR_HI_LO | {6'b0, high_bits}})
                    : '0;
    enc_c = flush_c ? jsu_pkg::utf8_encode({5'b0, jsu_pkg::SURR_HI_LO | {6'b0, high_bits_next}})
                    : '0;
    if (use_raw) begin
      enc_b = '{len: 3'd1, b: {24'h0, raw}};
    end else if (use_cp) begin
      enc_b = jsu_pkg::utf8_encode(cp);
    end else begin
      enc_b = '0;
    end
    len_ab = enc_a.len + enc_b.len;
    ntot = {1'b0, enc_a.len} + {1'b0, enc_b.len} + {1'b0, enc_c.len};
  end

  always_comb begin
    cap_eff = (cap > jsu_pkg::CAP_LIMIT) ? jsu_pkg::CAP_LIMIT : cap;
    room = (bytes_written + 17'd1 < cap_eff) ? cap_eff - bytes_written - 17'd1 : '0;
    if (overflow) begin
      emit = 3'd0;
    end else if (room < 17'(ntot)) begin
      emit = room[2:0];
    end else begin
      emit = ntot[2:0];
    end
    overflow_next = overflow || (17'(ntot) > room);
    bytes_written_next = bytes_written + 17'(emit);
  end

  always_comb begin
    pkt.bytes = 48'(enc_a.b) | (48'(enc_b.b) << {enc_a.len, 3'b000})
              | (48'(enc_c.b) << {len_ab, 3'b000});
    pkt.nbytes = emit;
    pkt.last = din.string_end;
    pkt.trunc = overflow_next;
    push = acc && (emit != 3'd0 || din.string_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= jsu_pkg::PH_TEXT;
      hex_value <= '0;
      digit_count <= '0;
      high_pending <= 1'b0;
      high_bits <= '0;
      bytes_written <= '0;
      overflow <= 1'b0;
    end else if (acc) begin
      if (din.string_end) begin
        phase <= jsu_pkg::PH_TEXT;
        hex_value <= '0;
        digit_count <= '0;
        high_pending <= 1'b0;
        high_bits <= '0;
        bytes_written <= '0;
        overflow <= 1'b0;
      end else begin
        phase <= phase_next;
        hex_value <= hex_value_next;
        digit_count <= digit_count_next;
        high_pending <= high_pending_next;
        high_bits <= high_bits_next;
        bytes_written <= bytes_written_next;
        overflow <= overflow_next;
      end
    end
  end

  a_budget: assert property (@(posedge clk) disable iff (rst)
    bytes_written < jsu_pkg::CAP_LIMIT)
    else $error("bytes_written reached the capacity limit");

endmodule

FILE: hdl/jsu_queue.sv
// Short packet queue between the front and back ends of the unescape block.
// Flip-flop storage, one write and one read port.
// Depends on jsu_pkg.
module jsu_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  jsu_pkg::pkt_t      din,
  input  logic               pop,
  output jsu_pkg::pkt_t      head,
  output jsu_pkg::q_status_t qs
);

  jsu_pkg::pkt_t mem [jsu_pkg::QDEPTH];
  logic [jsu_pkg::QAW-1:0] wr_ptr, rd_ptr;
  logic [jsu_pkg::QAW:0]   cnt;

  assign qs.full = cnt == (jsu_pkg::QAW + 1)'(jsu_pkg::QDEPTH);
  assign qs.empty = cnt == '0;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      cnt <= cnt + (jsu_pkg::QAW + 1)'(push) - (jsu_pkg::QAW + 1)'(pop);
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst) push |-> !qs.full)
    else $error("packet pushed into a full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst) pop |-> !qs.empty)
    else $error("packet popped from an empty queue");

endmodule

FILE: hdl/jsu_back.sv
// Back end of the unescape block: walks the head packet one byte per cycle into the
// registered output channel while dout.ready allows. Depends on jsu_pkg and jsu_out_if.
module jsu_back (
  input  logic               clk,
  input  logic               rst,
  input  jsu_pkg::pkt_t      head,
  input  jsu_pkg::q_status_t qs,
  output logic               pop,
  jsu_out_if.source          dout
);

  logic [jsu_pkg::NB_W-1:0] idx;
  logic [jsu_pkg::NB_W-1:0] nres;
  logic       load, is_last, bare;
  logic       ovalid;
  logic [7:0] obyte;
  logic       obvalid, orun_last, odone, otrunc;

  assign bare = head.nbytes == '0;
  assign nres = bare ? 3'd1 : head.nbytes;
  assign load = !qs.empty && (!ovalid || dout.ready);
  assign is_last = idx == nres - 3'd1;
  assign pop = load && is_last;

  assign dout.valid = ovalid;
  assign dout.out_byte = obyte;
  assign dout.byte_valid = obvalid;
  assign dout.run_last = orun_last;
  assign dout.string_done = odone;
  assign dout.truncated = otrunc;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      idx <= '0;
    end else if (load) begin
      ovalid <= 1'b1;
      idx <= is_last ? '0 : idx + 3'd1;
    end else if (dout.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      obyte <= bare ? 8'h00 : head.bytes[{idx, 3'b000} +: 8];
      obvalid <= !bare;
      orun_last <= is_last;
      odone <= is_last && head.last;
      otrunc <= head.trunc;
    end
  end

  a_bare_end: assert property (@(posedge clk) disable iff (rst)
    ovalid && !obvalid |-> orun_last && odone)
    else $error("bare result is not the closing result of a string");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    ovalid && odone |-> orun_last)
    else $error("string end marked on a result that is not the last of its request");

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for json_string_unescape_utf8: drives escaped string bytes,
// predicts the decoded UTF-8 results in a scoreboard class and checks every result.
// Depends on jsu_pkg, the jsu_in_if and jsu_out_if interfaces and the RTL top level.

typedef struct packed {
  logic [7:0] data;
  logic       byte_valid;
  logic       run_last;
  logic       string_done;
  logic       truncated;
} utf8_result_t;

class unescape_scoreboard;
  logic [jsu_pkg::CAP_W-1:0] capacity;
  jsu_pkg::phase_t  phase;
  logic [15:0]      hex_acc;
  logic [1:0]       digits;
  logic             high_held;
  logic [9:0]       high_part;
  int unsigned      written;
  logic             overflow;
  logic [7:0]       burst[$];
  utf8_result_t     expected_bytes[$];
  int               errors;

  function new();
    capacity = jsu_pkg::CAP_RESET;
    errors = 0;
    clear_string();
  endfunction

  function void clear_string();
    phase = jsu_pkg::PH_TEXT;
    hex_acc = '0;
    digits = '0;
    high_held = 1'b0;
    high_part = '0;
    written = 0;
    overflow = 1'b0;
  endfunction

  function int pending();
    return expected_bytes.size();
  endfunction

  function void put_byte(logic [7:0] b);
    int unsigned lim;
    lim = 32'((capacity > jsu_pkg::CAP_LIMIT) ? jsu_pkg::CAP_LIMIT : capacity);
    if (!overflow && written + 1 < lim) begin
      burst.push_back(b);
      written++;
    end else begin
      overflow = 1'b1;
    end
  endfunction

  function void emit_code_point(logic [20:0] cp);
    if (cp < 21'h80) begin
      put_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      put_byte({3'b110, cp[10:6]});
      put_byte({2'b10, cp[5:0]});
    end else if (cp < jsu_pkg::SUPP_BASE) begin
      put_byte({4'b1110, cp[15:12]});
      put_byte({2'b10, cp[11:6]});
      put_byte({2'b10, cp[5:0]});
    end else begin
      put_byte({5'b11110, cp[20:18]});
      put_byte({2'b10, cp[17:12]});
      put_byte({2'b10, cp[11:6]});
      put_byte({2'b10, cp[5:0]});
    end
  endfunction

  function void flush_high();
    if (high_held) begin
      high_held = 1'b0;
      emit_code_point(21'(jsu_pkg::SURR_HI_LO | 16'(high_part)));
    end
  endfunction

  function logic [3:0] hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
    return 4'h0;
  endfunction

  function logic [7:0] unescape(logic [7:0] e);
    case (e)
      jsu_pkg::CH_B: return 8'h08;
      jsu_pkg::CH_F: return 8'h0C;
      jsu_pkg::CH_N: return 8'h0A;
      jsu_pkg::CH_R: return 8'h0D;
      jsu_pkg::CH_T: return 8'h09;
      default:       return e;
    endcase
  endfunction

  function void complete_unit(logic [15:0] cp);
    if (high_held && cp >= jsu_pkg::SURR_LO_LO && cp <= jsu_pkg::SURR_LO_HI) begin
      high_held = 1'b0;
      emit_code_point(jsu_pkg::SUPP_BASE + 21'({high_part, 10'b0})
                      + 21'(cp - jsu_pkg::SURR_LO_LO));
      return;
    end
    flush_high();
    if (cp >= jsu_pkg::SURR_HI_LO && cp <= jsu_pkg::SURR_HI_HI) begin
      high_held = 1'b1;
      high_part = cp[9:0];
    end else begin
      emit_code_point(21'(cp));
    end
  endfunction

  function void add_request(logic [7:0] b, logic last);
    utf8_result_t r;
    burst.delete();
    case (phase)
      jsu_pkg::PH_ESC: begin
        if (b == jsu_pkg::CH_U) begin
          phase = jsu_pkg::PH_HEX;
          digits = '0;
          hex_acc = '0;
        end else begin
          flush_high();
          put_byte(unescape(b));
          phase = jsu_pkg::PH_TEXT;
        end
      end
      jsu_pkg::PH_HEX: begin
        hex_acc = {hex_acc[11:0], hex_nibble(b)};
        if (digits == 2'd3) begin
          phase = jsu_pkg::PH_TEXT;
          digits = '0;
          complete_unit(hex_acc);
        end else begin
          digits++;
        end
      end
      default: begin
        phase = jsu_pkg::PH_TEXT;
        if (b == jsu_pkg::CH_BSLASH) begin
          phase = jsu_pkg::PH_ESC;
        end else begin
          flush_high();
          put_byte(b);
        end
      end
    endcase
    if (last) flush_high();
    foreach (burst[k]) begin
      r.data = burst[k];
      r.byte_valid = 1'b1;
      r.run_last = (k == burst.size() - 1);
      r.string_done = (k == burst.size() - 1) && last;
      r.truncated = overflow;
      expected_bytes.push_back(r);
    end
    if (last && burst.size() == 0) begin
      r = '{data: 8'h00, byte_valid: 1'b0, run_last: 1'b1, string_done: 1'b1,
            truncated: overflow};
      expected_bytes.push_back(r);
    end
    if (last) clear_string();
  endfunction

  function void check_byte(utf8_result_t got);
    utf8_result_t want;
    if (expected_bytes.size() == 0) begin
      $error("unexpected result: out_byte %02h", got.data);
      errors++;
      return;
    end
    want = expected_bytes.pop_front();
    if (got.data !== want.data) begin
      $error("out_byte: expected %02h, got %02h", want.data, got.data);
      errors++;
    end
    if (got.byte_valid !== want.byte_valid) begin
      $error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
      errors++;
    end
    if (got.run_last !== want.run_last) begin
      $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
      errors++;
    end
    if (got.string_done !== want.string_done) begin
      $error("string_done: expected %0b, got %0b", want.string_done, got.string_done);
      errors++;
    end
    if (got.truncated !== want.truncated) begin
      $error("truncated: expected %0b, got %0b", want.truncated, got.truncated);
      errors++;
    end
  endfunction
endclass

module testbench;
  localparam int HOLD_CYCLES = 160;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [jsu_pkg::CFG_AW-1:0] CAP_ADDR = {jsu_pkg::REG_CAPACITY, 2'b00};

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [jsu_pkg::CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  jsu_in_if  req_ch();
  jsu_out_if res_ch();

  json_string_unescape_utf8 dut (
    .clk(clk),
    .rst(rst),
    .din(req_ch),
    .dout(res_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  unescape_scoreboard sb;
  utf8_result_t seen;
  logic [7:0] text_q[$];
  logic [7:0] escapes[8];
  int sent_items;
  int idle_cycles;
  bit quiet;
  bit hold_req;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen.data = res_ch.out_byte;
      seen.byte_valid = res_ch.byte_valid;
      seen.run_last = res_ch.run_last;
      seen.string_done = res_ch.string_done;
      seen.truncated = res_ch.truncated;
      sb.check_byte(seen);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    res_ch.ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        res_ch.ready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end else begin
        res_ch.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic apb_cycle(input logic wr, input logic [31:0] wdata,
                           output logic [31:0] rdata);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = CAP_ADDR;
    pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic read_capacity(input logic [jsu_pkg::CAP_W-1:0] want);
    logic [31:0] rd;
    apb_cycle(1'b0, 32'h0, rd);
    if (rd !== 32'(want)) begin
      $error("capacity: expected %0h, got %0h", want, rd);
      sb.errors++;
    end
  endtask

  task automatic set_capacity(input logic [31:0] v);
    logic [31:0] rd;
    apb_cycle(1'b1, v, rd);
    sb.capacity = v[jsu_pkg::CAP_W-1:0];
    read_capacity(v[jsu_pkg::CAP_W-1:0]);
  endtask

  task automatic send_request(input logic [7:0] b, input logic last);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.in_byte = b;
    req_ch.string_end = last;
    do @(posedge clk); while (!req_ch.ready);
    sb.add_request(b, last);
    sent_items++;
  endtask

  task automatic send_string();
    foreach (text_q[i]) send_request(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + 8'(n);
    return ($urandom_range(0, 1) ? "A" : "a") + 8'(n) - 8'd10;
  endfunction

  task automatic push_unit(input logic [15:0] v);
    text_q.push_back(jsu_pkg::CH_BSLASH);
    text_q.push_back(jsu_pkg::CH_U);
    for (int i = 3; i >= 0; i--) begin
      if ($urandom_range(0, 15) == 0) text_q.push_back(8'($urandom_range(0, 255)));
      else text_q.push_back(hex_char(v[4*i +: 4]));
    end
  endtask

  task automatic build_string();
    int ntok;
    logic [7:0] b;
    logic [9:0] r;
    text_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        b = $urandom_range(0, 3) == 0 ? jsu_pkg::CH_BSLASH : 8'($urandom_range(0, 255));
        text_q.push_back(b);
      end
      return;
    end
    ntok = $urandom_range(1, 6);
    repeat (ntok) begin
      r = 10'($urandom_range(0, 1023));
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          b = 8'($urandom_range(0, 255));
          if (b == jsu_pkg::CH_BSLASH) text_q.push_back(jsu_pkg::CH_BSLASH);
          text_q.push_back(b);
        end
        3: begin
          text_q.push_back(jsu_pkg::CH_BSLASH);
          text_q.push_back(escapes[$urandom_range(0, 7)]);
        end
        4: begin
          b = 8'($urandom_range(0, 255));
          if (b == jsu_pkg::CH_U) b = jsu_pkg::CH_T;
          text_q.push_back(jsu_pkg::CH_BSLASH);
          text_q.push_back(b);
        end
        5: push_unit(16'($urandom_range(0, 16'hFFFF)));
        6: begin
          push_unit(jsu_pkg::SURR_HI_LO + 16'(r));
          push_unit(jsu_pkg::SURR_LO_LO + 16'($urandom_range(0, 1023)));
        end
        7: push_unit(jsu_pkg::SURR_HI_LO + 16'(r));
        8: push_unit(jsu_pkg::SURR_LO_LO + 16'(r));
        default: push_unit(16'($urandom_range(0, 16'h7FF)));
      endcase
    end
    if ($urandom_range(0, 7) == 0) begin
      text_q.push_back(jsu_pkg::CH_BSLASH);
      if ($urandom_range(0, 1)) begin
        text_q.push_back(jsu_pkg::CH_U);
        repeat ($urandom_range(0, 3)) text_q.push_back(hex_char(4'($urandom_range(0, 15))));
      end
    end
  endtask

  task automatic run_phase(input logic [31:0] cap, input int n_items, input bit long_hold);
    int first;
    set_capacity(cap);
    first = sent_items;
    if (long_hold) begin
      hold_req = 1'b1;
      text_q.delete();
      repeat (24) text_q.push_back(8'($urandom_range(8'h20, 8'h5B)));
      send_string();
    end
    while (sent_items - first < n_items) begin
      build_string();
      send_string();
    end
    drain();
  endtask

  initial begin
    sb = new();
    escapes = '{"\"", jsu_pkg::CH_BSLASH, "/", jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N,
                jsu_pkg::CH_R, jsu_pkg::CH_T};
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.in_byte = 8'h00;
    req_ch.string_end = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sent_items = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    read_capacity(jsu_pkg::CAP_RESET);
    text_q = '{8'h00, 8'hFF, jsu_pkg::CH_BSLASH, jsu_pkg::CH_N, jsu_pkg::CH_BSLASH, "q"};
    send_string();
    text_q = '{jsu_pkg::CH_BSLASH, jsu_pkg::CH_U, "d", "8", "3", "d",
               jsu_pkg::CH_BSLASH, jsu_pkg::CH_U, "D", "E", "0", "G"};
    send_string();
    text_q = '{jsu_pkg::CH_BSLASH, jsu_pkg::CH_U, "D", "B", "F", "F"};
    send_string();
    text_q = '{jsu_pkg::CH_BSLASH};
    send_string();
    drain();

    run_phase(32'd0, 5, 1'b0);
    run_phase(32'd1, 5, 1'b0);
    run_phase(32'd2, 5, 1'b0);
    run_phase(32'd3, 5, 1'b0);
    run_phase(32'd7, 6, 1'b0);
    run_phase(32'h1FFFF, 30, 1'b1);
    run_phase(32'(jsu_pkg::CAP_LIMIT), 5, 1'b0);
    run_phase(32'($urandom_range(4, 24)), 6, 1'b0);
    quiet = 1'b1;
    run_phase(32'(jsu_pkg::CAP_RESET), 8, 1'b0);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

FILE: sim.f
hdl/jsu_pkg.sv
hdl/jsu_if.sv
hdl/jsu_front.sv
hdl/jsu_queue.sv
hdl/jsu_back.sv
hdl/json_string_unescape_utf8.sv
sim/testbench.sv
